// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_AT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_AT(lbl, clk, rstn, prop)

`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ===== sv/fph_pkg.sv =====
package fph_pkg;

  localparam int CMD_W        = 2;
  localparam int HOLE_W       = 16;
  localparam int SLOT_W       = 5;
  localparam int FIT_POLICY_W = 2;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;

  localparam int REG_FIT_POLICY = 0;

  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REQ   = 2'd2;

  localparam logic [FIT_POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [FIT_POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [FIT_POLICY_W-1:0] POL_WORST = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [HOLE_W-1:0] size_kb;
  } in_item_t;

  typedef struct packed {
    logic              placed;
    logic [SLOT_W-1:0] slot;
    logic [HOLE_W-1:0] hole_before;
    logic [HOLE_W-1:0] hole_after;
  } out_item_t;

  typedef struct packed {
    logic idle;
    logic issue;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_is_req;
    logic issue_last;
    logic cmp_busy;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== sv/fph_ram.sv =====
module fph_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

  assign rdata = rd_data_r;

endmodule

// ===== sv/fph_ctrl.sv =====
module fph_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  fph_pkg::dp_stat_t  stat,
  output fph_pkg::ctrl_cmd_t cmd
);
  import fph_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.idle = 1'b1;
        if (in_valid && stat.in_is_req) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue = !stat.issue_last;
        if (stat.issue_last && !stat.cmp_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.finish = stat.out_free;
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/fph_dp.sv =====
`include "assert_macros.svh"

module fph_dp #(
  parameter int MAX_HOLES = 32,
  parameter int SIZE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fph_pkg::ctrl_cmd_t                  cmd,
  output fph_pkg::dp_stat_t                   stat,
  input  logic                                in_valid,
  input  fph_pkg::in_item_t                   in_data,
  input  logic [fph_pkg::FIT_POLICY_W-1:0]    fit_policy,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fph_pkg::out_item_t                  out_data
);
  import fph_pkg::*;

  localparam int IDX_W = $clog2(MAX_HOLES);
  localparam int CNT_W = $clog2(MAX_HOLES + 1);

  logic [CNT_W-1:0]     hole_count_r, hole_count_nxt;
  logic [SIZE_BITS-1:0] req_size_r, req_size_nxt;
  logic [CNT_W-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic                 cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]     cmp_idx_r, cmp_idx_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic [SIZE_BITS-1:0] best_size_r, best_size_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic                 accept;
  logic                 load_we;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;
  logic [SIZE_BITS-1:0] ram_rdata;
  logic [SIZE_BITS-1:0] in_size;
  logic [SIZE_BITS-1:0] shrunk;
  logic                 fits;
  logic                 take;

  assign accept    = in_valid && cmd.idle;
  assign in_size   = SIZE_BITS'(in_data.size_kb);
  assign load_we   = accept && (in_data.cmd == CMD_LOAD) &&
                     (hole_count_r < CNT_W'(MAX_HOLES));
  assign shrunk    = best_size_r - req_size_r;

  assign ram_we    = load_we || (cmd.finish && found_r);
  assign ram_waddr = load_we ? hole_count_r[IDX_W-1:0] : best_idx_r;
  assign ram_wdata = load_we ? in_size : shrunk;

  fph_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_HOLES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_cnt_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign fits = cmp_vld_r && (ram_rdata >= req_size_r);
  assign take = fits && (!found_r ||
                ((fit_policy == POL_BEST) && (ram_rdata < best_size_r)) ||
                ((fit_policy == POL_WORST) && (ram_rdata > best_size_r)));

  assign stat.in_is_req  = (in_data.cmd == CMD_REQ);
  assign stat.issue_last = (scan_cnt_r == hole_count_r);
  assign stat.cmp_busy   = cmp_vld_r;
  assign stat.out_free   = !out_valid_r || !out_stall;

  always_comb begin
    hole_count_nxt = hole_count_r;
    req_size_nxt   = req_size_r;
    scan_cnt_nxt   = scan_cnt_r;
    cmp_vld_nxt    = cmd.issue;
    cmp_idx_nxt    = scan_cnt_r[IDX_W-1:0];
    found_nxt      = found_r;
    best_idx_nxt   = best_idx_r;
    best_size_nxt  = best_size_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    if (accept) begin
      case (in_data.cmd)
        CMD_CLEAR: begin
          hole_count_nxt = '0;
        end
        CMD_LOAD: begin
          if (load_we) begin
            hole_count_nxt = hole_count_r + CNT_W'(1);
          end
        end
        CMD_REQ: begin
          req_size_nxt = in_size;
          scan_cnt_nxt = '0;
          found_nxt    = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (cmd.issue) begin
      scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
    end

    if (take) begin
      found_nxt     = 1'b1;
      best_idx_nxt  = cmp_idx_r;
      best_size_nxt = ram_rdata;
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      if (found_r) begin
        out_data_nxt.placed      = 1'b1;
        out_data_nxt.slot        = SLOT_W'(best_idx_r);
        out_data_nxt.hole_before = HOLE_W'(best_size_r);
        out_data_nxt.hole_after  = HOLE_W'(shrunk);
      end else begin
        out_data_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hole_count_r <= '0;
      cmp_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      hole_count_r <= hole_count_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_size_r  <= req_size_nxt;
    scan_cnt_r  <= scan_cnt_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_size_r <= best_size_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_AT(a_count_bound, clk, rst_n, hole_count_r <= CNT_W'(MAX_HOLES))
  `ASSERT_NEVER(a_write_clash, clk, rst_n, load_we && cmd.finish)
  `ASSERT_AT(a_best_fits, clk, rst_n, found_r |-> (best_size_r >= req_size_r))

endmodule

// ===== sv/fit_policy_hole_allocator.sv =====
// Request: accepted while idle, then the table is scanned one entry per cycle and the
// result is registered to out_valid and out_data once the output is free.
// Requests do not overlap: in_stall stays high until that result is registered;
// a stalled result holds off the next transfer.
// Clear and load: accepted while idle, no result.
// Reset (rst_n low, synchronous): table empty, fit_policy 0; hole sizes stay undefined.
module fit_policy_hole_allocator #(
  parameter int MAX_HOLES = 32,
  parameter int SIZE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  fph_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output fph_pkg::out_item_t                out_data,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fph_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [fph_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [fph_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import fph_pkg::*;

  logic [FIT_POLICY_W-1:0] fit_policy_r, fit_policy_nxt;
  logic                    reg_hit;
  ctrl_cmd_t               cmd;
  dp_stat_t                stat;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == 1'(REG_FIT_POLICY));
  assign prdata  = reg_hit ? CFG_DATA_W'(fit_policy_r) : '0;

  always_comb begin
    fit_policy_nxt = fit_policy_r;
    if (psel && penable && pwrite && pready && reg_hit) begin
      fit_policy_nxt = pwdata[FIT_POLICY_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r <= POL_FIRST;
    end else begin
      fit_policy_r <= fit_policy_nxt;
    end
  end

  assign in_stall = !cmd.idle;

  fph_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  fph_dp #(
    .MAX_HOLES (MAX_HOLES),
    .SIZE_BITS (SIZE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .fit_policy (fit_policy_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import fph_pkg::*;

  localparam int HOLES         = 32;
  localparam int SETTLE_CYCLES = HOLES + 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SEGMENTS      = 12;
  localparam int SEGMENT_ITEMS = 94;

  class placement_board;
    logic [FIT_POLICY_W-1:0] policy;
    logic [HOLE_W-1:0]       holes[HOLES];
    int unsigned             n_holes;
    out_item_t               placements[$];
    int unsigned             errors;

    function new();
      policy  = POL_FIRST;
      n_holes = 0;
      errors  = 0;
    endfunction

    function int pending();
      return placements.size();
    endfunction

    function void note_input(in_item_t it);
      out_item_t r;
      int        pick;
      case (it.cmd)
        CMD_CLEAR: n_holes = 0;
        CMD_LOAD: begin
          if (n_holes < HOLES) begin
            holes[n_holes] = it.size_kb;
            n_holes++;
          end
        end
        CMD_REQ: begin
          pick = -1;
          for (int i = 0; i < n_holes; i++) begin
            if (holes[i] >= it.size_kb) begin
              if (pick < 0) pick = i;
              else if (policy == POL_BEST && holes[i] < holes[pick]) pick = i;
              else if (policy == POL_WORST && holes[i] > holes[pick]) pick = i;
            end
          end
          r = '0;
          if (pick >= 0) begin
            r.placed      = 1'b1;
            r.slot        = SLOT_W'(pick);
            r.hole_before = holes[pick];
            r.hole_after  = holes[pick] - it.size_kb;
            holes[pick]   = r.hole_after;
          end
          placements.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, logic [HOLE_W-1:0] want,
                                logic [HOLE_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (placements.size() == 0) begin
        $display("%0t: placement with none outstanding, expected nothing, got %p",
                 $time, got);
        errors++;
        return;
      end
      want = placements.pop_front();
      compare_field("placed", HOLE_W'(want.placed), HOLE_W'(got.placed));
      compare_field("slot", HOLE_W'(want.slot), HOLE_W'(got.slot));
      compare_field("hole_before", want.hole_before, got.hole_before);
      compare_field("hole_after", want.hole_after, got.hole_after);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  placement_board board;
  int                    send_idle_pct;
  int                    recv_idle_pct;
  bit                    start_hold;

  fit_policy_hole_allocator #(
    .MAX_HOLES(HOLES),
    .SIZE_BITS(HOLE_W)
  ) dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && !out_stall) board.check_result(out_data);
      if (start_hold) begin
        start_hold = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [HOLE_W-1:0] size);
    in_item_t it;
    it.cmd     = cmd;
    it.size_kb = size;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    board.note_input(it);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == CFG_ADDR_W'(4 * REG_FIT_POLICY)) board.policy = value[FIT_POLICY_W-1:0];
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_segment(input int quota);
    int                sent;
    int                n_loads;
    int                n_reqs;
    int                style;
    logic [HOLE_W-1:0] cap;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(99) < 85) begin
        style = $urandom_range(2);
        cap   = (style == 0) ? 16'hFFFF : (style == 1) ? 16'd15 : 16'd4000;
        if ($urandom_range(4) != 0) begin
          send_item(CMD_CLEAR, HOLE_W'($urandom()));
          sent++;
        end
        n_loads = ($urandom_range(9) == 0) ? $urandom_range(36, 28) : $urandom_range(10, 1);
        repeat (n_loads) send_item(CMD_LOAD, HOLE_W'($urandom_range(cap)));
        n_reqs = $urandom_range(8, 1);
        repeat (n_reqs) begin
          send_item(CMD_REQ, ($urandom_range(7) == 0) ? '0 : HOLE_W'($urandom_range(cap)));
        end
        sent += n_loads + n_reqs;
      end else begin
        style = $urandom_range(3);
        send_item(CMD_W'(style), HOLE_W'($urandom()));
        if (style != 3) sent++;
      end
    end
  endtask

  initial begin
    int pol;
    board         = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    send_idle_pct = 0;
    recv_idle_pct = 30;
    start_hold    = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(CMD_REQ, 16'd5);
    send_item(2'd3, 16'hFFFF);
    send_item(CMD_LOAD, 16'hFFFF);
    send_item(CMD_LOAD, 16'd0);
    send_item(CMD_LOAD, 16'd100);
    send_item(CMD_LOAD, 16'd300);
    send_item(CMD_LOAD, 16'd200);
    send_item(CMD_REQ, 16'd0);
    send_item(CMD_REQ, 16'hFFFF);
    send_item(CMD_REQ, 16'd150);
    send_item(CMD_REQ, 16'd1000);
    drain();
    cfg_write(CFG_ADDR_W'(4 * REG_FIT_POLICY), CFG_DATA_W'(POL_BEST));
    send_item(CMD_CLEAR, 16'd0);
    send_item(CMD_LOAD, 16'd50);
    send_item(CMD_LOAD, 16'd20);
    send_item(CMD_LOAD, 16'd20);
    send_item(CMD_LOAD, 16'd80);
    send_item(CMD_REQ, 16'd20);
    send_item(CMD_REQ, 16'd30);
    drain();
    cfg_write(CFG_ADDR_W'(4 * REG_FIT_POLICY), CFG_DATA_W'(POL_WORST));
    send_item(CMD_REQ, 16'd10);
    send_item(CMD_LOAD, 16'd70);
    send_item(CMD_REQ, 16'd70);
    send_item(CMD_CLEAR, 16'hFFFF);
    drain();
    cfg_write(CFG_ADDR_W'(4 * (REG_FIT_POLICY + 1)), CFG_DATA_W'($urandom()));

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain();
      pol = (seg + seg / 4) % 4;
      cfg_write(CFG_ADDR_W'(4 * REG_FIT_POLICY),
                ($urandom() & ~CFG_DATA_W'(3)) | CFG_DATA_W'(pol));
      case (seg / 4)
        0: begin
          send_idle_pct = 7;
          recv_idle_pct = 77;
        end
        1: begin
          send_idle_pct = 77;
          recv_idle_pct = 7;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // hold the result side while requests keep coming
      if (seg == 8) start_hold = 1'b1;
      run_segment(SEGMENT_ITEMS);
    end

    drain();
    if (board.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
